@@ rtl/adc_moving_average_change_reporter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the moving-average change reporter
// Shared by every RTL file that checks its own logic; uses clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ADC_MOVING_AVERAGE_CHANGE_REPORTER_DEFINES_SVH
`define ADC_MOVING_AVERAGE_CHANGE_REPORTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AMACR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define AMACR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/amacr_pkg.sv @@
// ----------------------------------------------------------------------------
// amacr_pkg
// Types and fixed constants of the moving-average change reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package amacr_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int MEAN_W     = 12;
	localparam int BUTTON_W   = 3;
	localparam int BYTE_W     = 8;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int SAMPLE_MAX = 4095;

	// input item kinds
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_BUTTON = 1'b1;

	// frame kinds
	localparam logic KIND_AVERAGE = 1'b0;
	localparam logic KIND_BUTTON  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_TAG       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER       = 2'd3;

	// register reset values
	localparam logic [CFG_W-1:0]  RST_CHANGE_THRESHOLD = 12'd100;
	localparam logic [BYTE_W-1:0] RST_START_MARKER     = 8'd65;
	localparam logic [BYTE_W-1:0] RST_VOLUME_TAG       = 8'd86;
	localparam logic [BYTE_W-1:0] RST_END_MARKER       = 8'd88;

	// valid button numbers and digit base
	localparam logic [BUTTON_W-1:0] BUTTON_MIN = 3'd1;
	localparam logic [BUTTON_W-1:0] BUTTON_MAX = 3'd5;
	localparam logic [BYTE_W-1:0]   ASCII_ZERO = 8'd48;

	typedef struct packed {
		logic                action;
		logic [SAMPLE_W-1:0] sample;
		logic [BUTTON_W-1:0] button;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              last_byte;
	} out_item_t;

	// item leaving the averaging pipeline
	typedef struct packed {
		logic                valid;
		logic                action;
		logic [BUTTON_W-1:0] button;
		logic [MEAN_W-1:0]   mean;
	} mean_stage_t;

	// frame handed to the byte emitter
	typedef struct packed {
		logic                kind;
		logic [MEAN_W-1:0]   mean;
		logic [BUTTON_W-1:0] button;
	} frame_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] volume_tag;
		logic [BYTE_W-1:0] end_marker;
	} markers_t;

endpackage

`default_nettype wire

@@ rtl/amacr_mean.sv @@
// ----------------------------------------------------------------------------
// amacr_mean
// Sample window and running sum; divides the sum by the window size.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_moving_average_change_reporter_defines.svh"

module amacr_mean #(
	parameter int WINDOW = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire amacr_pkg::in_item_t  in_item,
	output amacr_pkg::mean_stage_t    stage
);

	localparam int SUM_MAX = WINDOW * amacr_pkg::SAMPLE_MAX;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	// exact floor division for every sum below 2**SUM_W
	localparam int SHIFT   = SUM_W + $clog2(WINDOW);
	localparam int RCP_W   = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic                                valid_s1;
	amacr_pkg::in_item_t                 item_s1;
	logic [amacr_pkg::SAMPLE_W-1:0]      ring_q [WINDOW];
	logic [SUM_W-1:0]                    sum_q;
	logic [SUM_W-1:0]                    sum_nx;
	logic                                shift_en;

	logic                                valid_s2;
	logic                                action_s2;
	logic [amacr_pkg::BUTTON_W-1:0]      button_s2;
	logic [SUM_W-1:0]                    sum_s2;
	logic [PROD_W-1:0]                   prod;

	logic                                valid_s3;
	logic                                action_s3;
	logic [amacr_pkg::BUTTON_W-1:0]      button_s3;
	logic [amacr_pkg::MEAN_W-1:0]        mean_s3;

	// stage 1: input register, and the valid bit of each stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
		end
	end

	// window shift and running sum: new sample in, oldest out
	assign shift_en = adv && valid_s1 && (item_s1.action == amacr_pkg::ACT_SAMPLE);
	assign sum_nx = SUM_W'(({1'b0, sum_q} + (SUM_W + 1)'(item_s1.sample))
		- (SUM_W + 1)'(ring_q[WINDOW-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
			sum_q <= '0;
		end else if (shift_en) begin
			ring_q[0] <= item_s1.sample;
			for (int i = 1; i < WINDOW; i++) ring_q[i] <= ring_q[i-1];
			sum_q <= sum_nx;
		end
	end

	// stage 2: sum after this item, if it is a sample
	always_ff @(posedge clk) begin
		if (adv) begin
			action_s2 <= item_s1.action;
			button_s2 <= item_s1.button;
			sum_s2    <= sum_nx;
		end
	end

	// stage 3: mean by reciprocal multiply
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s3 <= action_s2;
			button_s3 <= button_s2;
			mean_s3   <= prod[SHIFT +: amacr_pkg::MEAN_W];
		end
	end

	assign stage.valid  = valid_s3;
	assign stage.action = action_s3;
	assign stage.button = button_s3;
	assign stage.mean   = mean_s3;

	`AMACR_ASSERT_NOW(sum_bound_a, 1'b1, sum_q <= SUM_W'(SUM_MAX), "running sum above window max")

endmodule

`default_nettype wire

@@ rtl/amacr_framer.sv @@
// ----------------------------------------------------------------------------
// amacr_framer
// Holds one frame and emits its bytes, one per cycle while the receiver does not stall, on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_moving_average_change_reporter_defines.svh"

module amacr_framer (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire amacr_pkg::frame_req_t req,
	input  wire amacr_pkg::markers_t   markers,
	output logic                       can_load,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output amacr_pkg::out_item_t       rsp_data
);

	// byte positions in a frame
	localparam logic [2:0] POS_START = 3'd0;
	localparam logic [2:0] POS_TAG   = 3'd1;
	localparam logic [2:0] POS_LOW   = 3'd2;
	localparam logic [2:0] POS_HIGH  = 3'd3;
	localparam logic [2:0] LAST_AVG  = 3'd4;
	localparam logic [2:0] LAST_BTN  = 3'd2;

	logic                           busy_q;
	logic [2:0]                     idx_q;
	logic                           kind_q;
	logic [amacr_pkg::MEAN_W-1:0]   mean_q;
	logic [amacr_pkg::BUTTON_W-1:0] button_q;
	logic [2:0]                     last_idx;
	logic                           last;
	logic [amacr_pkg::BYTE_W-1:0]   digit;
	logic [amacr_pkg::BYTE_W-1:0]   byte_sel;

	assign last_idx = (kind_q == amacr_pkg::KIND_BUTTON) ? LAST_BTN : LAST_AVG;
	assign last     = (idx_q == last_idx);
	assign can_load = !busy_q || (!rsp_stall && last);

	// frame control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= POS_START;
		end else if (busy_q && !rsp_stall) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= req.kind;
			mean_q   <= req.mean;
			button_q <= req.button;
		end
	end

	// byte select
	assign digit = amacr_pkg::ASCII_ZERO + amacr_pkg::BYTE_W'(button_q);

	always_comb begin
		byte_sel = markers.end_marker;
		if (kind_q == amacr_pkg::KIND_AVERAGE) begin
			case (idx_q)
				POS_START: byte_sel = markers.start_marker;
				POS_TAG:   byte_sel = markers.volume_tag;
				POS_LOW:   byte_sel = mean_q[7:0];
				POS_HIGH:  byte_sel = {4'b0000, mean_q[11:8]};
				default:   byte_sel = markers.end_marker;
			endcase
		end else begin
			case (idx_q)
				POS_START: byte_sel = markers.start_marker;
				POS_TAG:   byte_sel = digit;
				default:   byte_sel = markers.end_marker;
			endcase
		end
	end

	assign rsp_valid           = busy_q;
	assign rsp_data.frame_byte = byte_sel;
	assign rsp_data.last_byte  = last;

	`AMACR_ASSERT_NOW(idx_range_a, busy_q, idx_q <= last_idx, "byte index past end of frame")
	`AMACR_ASSERT_NEXT(frame_done_a, busy_q && !rsp_stall && last && !load, !busy_q, "frame not closed after last byte")

endmodule

`default_nettype wire

@@ rtl/adc_moving_average_change_reporter.sv @@
// ----------------------------------------------------------------------------
// adc_moving_average_change_reporter: moving average with change frames
// Items pass the input, sum, mean and frame registers; 1 item per cycle unless
// a frame waits for the emitter. A reporting item sends 5 frame bytes (average)
// or 3 (button) via the single frame emitter; reset clears the window.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_moving_average_change_reporter_defines.svh"

module adc_moving_average_change_reporter #(
	parameter int WINDOW = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire amacr_pkg::in_item_t                 req_data,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output amacr_pkg::out_item_t                     rsp_data,
	input  wire logic                                cfg_we,
	input  wire logic [amacr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [amacr_pkg::CFG_W-1:0]         cfg_wdata
);

	logic [amacr_pkg::CFG_W-1:0]  threshold_q;
	amacr_pkg::markers_t          markers_q;
	logic [amacr_pkg::MEAN_W-1:0] reported_q;

	amacr_pkg::mean_stage_t       st_s3;
	amacr_pkg::frame_req_t        req;
	logic [amacr_pkg::MEAN_W-1:0] diff;
	logic                         hit;
	logic                         btn_ok;
	logic                         emit;
	logic                         can_load;
	logic                         adv;
	logic                         load;
	logic                         upd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q            <= amacr_pkg::RST_CHANGE_THRESHOLD;
			markers_q.start_marker <= amacr_pkg::RST_START_MARKER;
			markers_q.volume_tag   <= amacr_pkg::RST_VOLUME_TAG;
			markers_q.end_marker   <= amacr_pkg::RST_END_MARKER;
		end else if (cfg_we) begin
			case (cfg_index)
				amacr_pkg::REG_CHANGE_THRESHOLD: threshold_q <= cfg_wdata;
				amacr_pkg::REG_START_MARKER: markers_q.start_marker <= cfg_wdata[7:0];
				amacr_pkg::REG_VOLUME_TAG:   markers_q.volume_tag   <= cfg_wdata[7:0];
				amacr_pkg::REG_END_MARKER:   markers_q.end_marker   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// averaging pipeline
	amacr_mean #(
		.WINDOW (WINDOW)
	) u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (req_valid),
		.in_item  (req_data),
		.stage    (st_s3)
	);

	// report decision on the item leaving the pipeline
	assign diff   = (st_s3.mean >= reported_q) ? (st_s3.mean - reported_q)
	                                           : (reported_q - st_s3.mean);
	assign hit    = (diff > threshold_q);
	assign btn_ok = (st_s3.button >= amacr_pkg::BUTTON_MIN)
	             && (st_s3.button <= amacr_pkg::BUTTON_MAX);
	assign emit   = st_s3.valid
	             && ((st_s3.action == amacr_pkg::ACT_SAMPLE) ? hit : btn_ok);

	// whole pipeline holds while a frame waits for the emitter
	assign adv       = !emit || can_load;
	assign req_stall = !adv;
	assign load      = emit && can_load;
	assign upd       = load && (st_s3.action == amacr_pkg::ACT_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= '0;
		end else if (upd) begin
			reported_q <= st_s3.mean;
		end
	end

	assign req.kind   = (st_s3.action == amacr_pkg::ACT_BUTTON) ? amacr_pkg::KIND_BUTTON
	                                                            : amacr_pkg::KIND_AVERAGE;
	assign req.mean   = st_s3.mean;
	assign req.button = st_s3.button;

	// frame byte emitter
	amacr_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.req       (req),
		.markers   (markers_q),
		.can_load  (can_load),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	`AMACR_ASSERT_NOW(no_overrun_a, req_valid && !req_stall, !(emit && !load), "item taken over a pending frame")
	`AMACR_ASSERT_NEXT(report_track_a, upd, reported_q == $past(st_s3.mean), "reported mean not updated")

endmodule

`default_nettype wire

@@ test/adc_moving_average_change_reporter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_moving_average_change_reporter_tb
// Sends converter samples and button events through the request channel and
// checks every frame byte against an in-bench model of the averaging window,
// the change threshold and the frame layout. The run moves through several
// register settings and several patterns of sender gaps and receiver stalls,
// including one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module adc_moving_average_change_reporter_tb;

	localparam int AVG_WINDOW    = 10;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	amacr_pkg::in_item_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	amacr_pkg::out_item_t rsp_data;
	logic cfg_we = 1'b0;
	logic [amacr_pkg::CFG_IDX_W-1:0] cfg_index = amacr_pkg::REG_CHANGE_THRESHOLD;
	logic [amacr_pkg::CFG_W-1:0] cfg_wdata = '0;

	// register mirror
	logic [amacr_pkg::CFG_W-1:0] threshold_q = amacr_pkg::RST_CHANGE_THRESHOLD;
	logic [amacr_pkg::BYTE_W-1:0] start_q = amacr_pkg::RST_START_MARKER;
	logic [amacr_pkg::BYTE_W-1:0] tag_q = amacr_pkg::RST_VOLUME_TAG;
	logic [amacr_pkg::BYTE_W-1:0] end_q = amacr_pkg::RST_END_MARKER;

	// averaging state mirror
	logic [amacr_pkg::SAMPLE_W-1:0] window_q [AVG_WINDOW];
	int slot_q = 0;
	logic [amacr_pkg::MEAN_W-1:0] last_mean_q = '0;

	amacr_pkg::in_item_t items_to_send [$];
	amacr_pkg::out_item_t frame_bytes_due [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int holds_asked = 0;
	int holds_granted = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	adc_moving_average_change_reporter #(
		.WINDOW(AVG_WINDOW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void push_byte(logic [amacr_pkg::BYTE_W-1:0] b, logic last);
		amacr_pkg::out_item_t o;
		o.frame_byte = b;
		o.last_byte = last;
		frame_bytes_due.push_back(o);
	endfunction

	// window update, change test and frame layout for one accepted item
	function automatic void predict_frames(amacr_pkg::in_item_t it);
		logic [15:0] sum;
		logic [amacr_pkg::MEAN_W-1:0] mean;
		logic [amacr_pkg::MEAN_W-1:0] diff;
		sum = '0;
		if (it.action == amacr_pkg::ACT_SAMPLE) begin
			window_q[slot_q] = it.sample;
			slot_q = (slot_q + 1 >= AVG_WINDOW) ? 0 : slot_q + 1;
			for (int i = 0; i < AVG_WINDOW; i++)
				sum += window_q[i];
			mean = amacr_pkg::MEAN_W'(sum / AVG_WINDOW);
			diff = (mean >= last_mean_q) ? mean - last_mean_q : last_mean_q - mean;
			if (diff > threshold_q) begin
				last_mean_q = mean;
				push_byte(start_q, 1'b0);
				push_byte(tag_q, 1'b0);
				push_byte(mean[7:0], 1'b0);
				push_byte({4'd0, mean[11:8]}, 1'b0);
				push_byte(end_q, 1'b1);
			end
		end else if (it.button >= amacr_pkg::BUTTON_MIN
				&& it.button <= amacr_pkg::BUTTON_MAX) begin
			push_byte(start_q, 1'b0);
			push_byte(amacr_pkg::ASCII_ZERO + amacr_pkg::BYTE_W'(it.button), 1'b0);
			push_byte(end_q, 1'b1);
		end
	endfunction

	// request driver: advance only when the held item went through
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				predict_frames(req_data);
			if (!req_valid || !req_stall) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_data <= items_to_send.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// frame byte checker and stall generator
	always @(posedge clk) begin
		amacr_pkg::out_item_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (frame_bytes_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected frame byte %02h last %0b", $time,
						rsp_data.frame_byte, rsp_data.last_byte);
				end else begin
					want = frame_bytes_due.pop_front();
					if (rsp_data.frame_byte !== want.frame_byte) begin
						mismatches++;
						$display("%0t: frame_byte expected %02h actual %02h", $time,
							want.frame_byte, rsp_data.frame_byte);
					end
					if (rsp_data.last_byte !== want.last_byte) begin
						mismatches++;
						$display("%0t: last_byte expected %0b actual %0b", $time,
							want.last_byte, rsp_data.last_byte);
					end
				end
			end
			// a requested hold-off is timed here, not by the stimulus
			if (holds_granted != holds_asked) begin
				holds_granted = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void push_sample(logic [amacr_pkg::SAMPLE_W-1:0] v);
		amacr_pkg::in_item_t it;
		it.action = amacr_pkg::ACT_SAMPLE;
		it.sample = v;
		it.button = amacr_pkg::BUTTON_W'($urandom_range(7));
		items_to_send.push_back(it);
	endfunction

	function automatic void push_button(logic [amacr_pkg::BUTTON_W-1:0] b);
		amacr_pkg::in_item_t it;
		it.action = amacr_pkg::ACT_BUTTON;
		it.sample = amacr_pkg::SAMPLE_W'($urandom_range(amacr_pkg::SAMPLE_MAX));
		it.button = b;
		items_to_send.push_back(it);
	endfunction

	// mostly samples drifting around a level or jumping, plus button events
	function automatic void fill_random(int n);
		int level;
		int r;
		logic [amacr_pkg::BUTTON_W-1:0] b;
		level = $urandom_range(amacr_pkg::SAMPLE_MAX);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				level = (level + $urandom_range(80) - 40) & amacr_pkg::SAMPLE_MAX;
				push_sample(amacr_pkg::SAMPLE_W'(level));
			end else if (r < 55) begin
				push_sample(amacr_pkg::SAMPLE_W'($urandom_range(amacr_pkg::SAMPLE_MAX)));
			end else if (r < 65) begin
				push_sample($urandom_range(1) ?
					amacr_pkg::SAMPLE_W'(amacr_pkg::SAMPLE_MAX) : '0);
			end else if (r < 92) begin
				push_button(amacr_pkg::BUTTON_W'($urandom_range(amacr_pkg::BUTTON_MAX,
					amacr_pkg::BUTTON_MIN)));
			end else begin
				// unknown button number, ignored by the block
				do
					b = amacr_pkg::BUTTON_W'($urandom_range(7));
				while (b >= amacr_pkg::BUTTON_MIN && b <= amacr_pkg::BUTTON_MAX);
				push_button(b);
			end
		end
	endfunction

	// registers change only here, with the block idle
	task automatic write_reg(logic [amacr_pkg::CFG_IDX_W-1:0] idx,
			logic [amacr_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			amacr_pkg::REG_CHANGE_THRESHOLD: threshold_q = val;
			amacr_pkg::REG_START_MARKER: start_q = val[amacr_pkg::BYTE_W-1:0];
			amacr_pkg::REG_VOLUME_TAG: tag_q = val[amacr_pkg::BYTE_W-1:0];
			amacr_pkg::REG_END_MARKER: end_q = val[amacr_pkg::BYTE_W-1:0];
			default: ;
		endcase
	endtask

	// upper bits of the marker data are junk that the block must drop
	task automatic set_registers(logic [amacr_pkg::CFG_W-1:0] thr,
			logic [amacr_pkg::BYTE_W-1:0] sm, logic [amacr_pkg::BYTE_W-1:0] vt,
			logic [amacr_pkg::BYTE_W-1:0] em);
		write_reg(amacr_pkg::REG_CHANGE_THRESHOLD, thr);
		write_reg(amacr_pkg::REG_START_MARKER, {4'($urandom_range(15)), sm});
		write_reg(amacr_pkg::REG_VOLUME_TAG, {4'($urandom_range(15)), vt});
		write_reg(amacr_pkg::REG_END_MARKER, {4'($urandom_range(15)), em});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (items_to_send.size() != 0 || req_valid || frame_bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(int send_pct, int hold_pct, int n);
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = hold_pct;
		fill_random(n);
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < AVG_WINDOW; i++)
			window_q[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: window fill at full scale, steady, drop and rise, all button numbers
		for (int k = 0; k < AVG_WINDOW + 1; k++)
			push_sample(amacr_pkg::SAMPLE_W'(amacr_pkg::SAMPLE_MAX));
		push_sample('0);
		push_sample('0);
		push_sample(12'd4000);
		for (int b = 0; b < 8; b++)
			push_button(amacr_pkg::BUTTON_W'(b));
		wait_idle();

		// report on any change, extreme marker values
		set_registers('0, 8'hFF, 8'h00, 8'hFF);
		run_random(46, 0, 92);

		// never report an average, only button frames
		set_registers(amacr_pkg::CFG_W'(amacr_pkg::SAMPLE_MAX), 8'h00, 8'hFF, 8'h00);
		run_random(0, 46, 92);

		set_registers(amacr_pkg::CFG_W'($urandom_range(200, 1)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		run_random(38, 38, 92);

		// long receiver hold-off while the sender keeps pushing
		set_registers(12'd20, 8'h5A, 8'hA5, 8'h3C);
		@(negedge clk);
		holds_asked++;
		run_random(0, 0, 92);

		// back to the power-up values
		set_registers(amacr_pkg::RST_CHANGE_THRESHOLD, amacr_pkg::RST_START_MARKER,
			amacr_pkg::RST_VOLUME_TAG, amacr_pkg::RST_END_MARKER);
		run_random(38, 38, 92);

		if (mismatches == 0 && frame_bytes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ adc_moving_average_change_reporter.f @@
+incdir+rtl
rtl/amacr_pkg.sv
rtl/amacr_mean.sv
rtl/amacr_framer.sv
rtl/adc_moving_average_change_reporter.sv
test/adc_moving_average_change_reporter_tb.sv
